// ===== rtl/anlp_pkg.sv =====
// ----------------------------------------------------------------------------
// anlp_pkg
// Shared types and constants of the ASCII number literal parser.
// ----------------------------------------------------------------------------
package anlp_pkg;

    localparam int VAL_W  = 63;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [VAL_W-1:0] VAL_MAX   = {VAL_W{1'b1}};
    localparam logic [VAL_W-1:0] DEC_LIMIT = VAL_MAX / 10;

    // parse phase codes
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_ZERO   = 3'd1;
    localparam logic [2:0] PH_DEC    = 3'd2;
    localparam logic [2:0] PH_HEXPFX = 3'd3;
    localparam logic [2:0] PH_HEX    = 3'd4;
    localparam logic [2:0] PH_ERR    = 3'd5;

    // register index
    localparam logic REG_HEX_PREFIX_ENABLE = 1'b0;

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_LX = 8'h78;
    localparam logic [7:0] CH_UX = 8'h58;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
        logic       end_only;
    } in_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             ok;
    } out_t;

endpackage

// ===== rtl/anlp_cfg.sv =====
// ----------------------------------------------------------------------------
// anlp_cfg
// APB register bank holding the hex prefix enable bit.
// ----------------------------------------------------------------------------
module anlp_cfg
    import anlp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic              hex_en
);

    logic hex_en_reg;
    logic hex_en_next;
    logic hit;

    assign pready = 1'b1;
    assign hit    = (paddr[ADDR_W-1:2] == REG_HEX_PREFIX_ENABLE);

    always_comb begin
        hex_en_next = hex_en_reg;
        if (psel && penable && pwrite && hit) begin
            hex_en_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hex_en_reg <= 1'b1;
        end else begin
            hex_en_reg <= hex_en_next;
        end
    end

    assign prdata = hit ? {{(DATA_W-1){1'b0}}, hex_en_reg} : '0;
    assign hex_en = hex_en_reg;

endmodule

// ===== rtl/anlp_step.sv =====
// ----------------------------------------------------------------------------
// anlp_step
// Next phase and accumulator for one character, plus the result it implies.
// ----------------------------------------------------------------------------
module anlp_step
    import anlp_pkg::*;
(
    input  logic [2:0]       phase,
    input  logic [VAL_W-1:0] acc,
    input  in_t              item,
    input  logic             hex_en,
    output logic [2:0]       phase_next,
    output logic [VAL_W-1:0] acc_next,
    output out_t             result
);

    logic [7:0]       c;
    logic             is_dec;
    logic             is_x;
    logic             is_hex;
    logic [3:0]       hval;
    logic [3:0]       dval;
    logic [VAL_W:0]   dec_sum;
    logic             dec_ovf;
    logic             hex_ovf;
    logic [2:0]       ph;
    logic [VAL_W-1:0] ac;

    assign c      = item.char_code;
    assign is_dec = (c >= CH_0) && (c <= CH_9);
    assign is_x   = (c == CH_LX) || (c == CH_UX);
    assign dval   = 4'(c - CH_0);

    always_comb begin
        is_hex = 1'b1;
        hval   = dval;
        if (is_dec) begin
            hval = dval;
        end else if ((c >= CH_LA) && (c <= CH_LF)) begin
            hval = 4'(c - CH_LA + 8'd10);
        end else if ((c >= CH_UA) && (c <= CH_UF)) begin
            hval = 4'(c - CH_UA + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
    end

    // acc * 10 + d; the product fits once acc is at most DEC_LIMIT
    assign dec_sum = ({1'b0, acc} << 3) + ({1'b0, acc} << 1) + (VAL_W+1)'(dval);
    assign dec_ovf = (acc > DEC_LIMIT) || dec_sum[VAL_W];
    assign hex_ovf = (acc[VAL_W-1 -: 4] != 4'd0);

    always_comb begin
        ph = phase;
        ac = acc;
        if (!item.end_only) begin
            unique case (phase)
                PH_START: begin
                    if (is_dec) begin
                        ac = VAL_W'(dval);
                        ph = (dval == 4'd0) ? PH_ZERO : PH_DEC;
                    end else begin
                        ph = PH_ERR;
                    end
                end
                PH_ZERO, PH_DEC: begin
                    if ((phase == PH_ZERO) && hex_en && is_x) begin
                        ac = '0;
                        ph = PH_HEXPFX;
                    end else if (is_dec && !dec_ovf) begin
                        ac = dec_sum[VAL_W-1:0];
                        ph = PH_DEC;
                    end else begin
                        ph = PH_ERR;
                    end
                end
                PH_HEXPFX, PH_HEX: begin
                    if (is_hex && !hex_ovf) begin
                        ac = {acc[VAL_W-5:0], hval};
                        ph = PH_HEX;
                    end else begin
                        ph = PH_ERR;
                    end
                end
                default: begin
                    ph = PH_ERR;
                end
            endcase
        end
    end

    assign phase_next   = ph;
    assign acc_next     = ac;
    assign result.ok    = (ph == PH_ZERO) || (ph == PH_DEC) || (ph == PH_HEX);
    assign result.value = result.ok ? ac : '0;

endmodule

// ===== rtl/ascii_number_literal_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_number_literal_parser
// Streams characters of a number literal in, one result per literal out.
// ----------------------------------------------------------------------------
// Usage:
//   Send one character per s_ transaction; set last_char on the final one,
//   or send end_only with last_char to close a literal (an empty one too).
//   Each literal ending yields one m_ transaction with value and ok;
//   items without last_char yield nothing.
//   Decimal is the default; with hex_prefix_enable set (APB address 0,
//   bit 0) a leading 0x or 0X selects hexadecimal. Values above 2^63-1 fail.
// Timing:
//   One character per cycle sustained while m_ is not stalled. A taken
//   transaction sits in the input register, is parsed there, and its result
//   goes via the result register to m_. The phase and accumulator update is
//   combinational: multiply-by-ten add and compare, or hex four-bit shift.
// Reset and stall:
//   Reset clears phase, accumulator and valid flags, sets hex_prefix_enable.
//   While m_valid is high and m_ready is low the result register holds, the
//   parse stage stops, and s_ready drops once the input register is full.
// ----------------------------------------------------------------------------
module ascii_number_literal_parser
    import anlp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // character stream
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    // results
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic             hex_en;
    logic             in_valid_reg;
    in_t              in_data_reg;
    logic [2:0]       phase_reg;
    logic [VAL_W-1:0] acc_reg;
    logic             out_valid_reg;
    out_t             out_data_reg;

    logic [2:0]       phase_next;
    logic [VAL_W-1:0] acc_next;
    out_t             result;
    logic             advance;
    logic             process;

    anlp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .hex_en  (hex_en)
    );

    anlp_step u_step (
        .phase      (phase_reg),
        .acc        (acc_reg),
        .item       (in_data_reg),
        .hex_en     (hex_en),
        .phase_next (phase_next),
        .acc_next   (acc_next),
        .result     (result)
    );

    assign advance = !out_valid_reg || m_ready;
    assign process = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_START;
            acc_reg       <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= process && in_data_reg.last_char;
            end
            if (process) begin
                // drop back to start once a literal is closed
                if (in_data_reg.last_char) begin
                    phase_reg <= PH_START;
                    acc_reg   <= '0;
                end else begin
                    phase_reg <= phase_next;
                    acc_reg   <= acc_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (process && in_data_reg.last_char) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
